// ----- rtl/sts_pkg.sv -----
// Package for the sector scan obstacle steering block.
// Types, register indices, reset values and the speed encoding shared by all rtl files.
// No dependencies.
package sts_pkg;

    // Default sizing, overridable on the top level
    localparam int RANGE_BITS_DEF        = 10;
    localparam int MAX_SWEEP_SAMPLES_DEF = 1024;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Fixed field widths
    localparam int ANGLE_W      = 8;
    localparam int SPEED_W      = 7;
    localparam int WHEEL_W      = 8;
    localparam int CFG_RANGE_W  = 10;

    // Depth of the queue between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // Sweep end detection and servo targets
    localparam logic [ANGLE_W-1:0] ANGLE_LOW  = 8'd1;
    localparam logic [ANGLE_W-1:0] ANGLE_HIGH = 8'd179;
    localparam logic [ANGLE_W-1:0] SERVO_FAR  = 8'd180;
    localparam logic [ANGLE_W-1:0] SERVO_NEAR = 8'd0;

    // Running minimum restarts from this value
    localparam int MIN_RESET = 255;

    // Register reset values
    localparam logic [CFG_RANGE_W-1:0] SAFE_RANGE_RST     = 10'd50;
    localparam logic [CFG_RANGE_W-1:0] CRITICAL_RANGE_RST = 10'd30;
    localparam logic [SPEED_W-1:0]     FAST_SPEED_RST     = 7'd10;
    localparam logic [SPEED_W-1:0]     SLOW_SPEED_RST     = 7'd5;
    localparam logic [ANGLE_W-1:0]     RIGHT_LIMIT_RST    = 8'd75;
    localparam logic [ANGLE_W-1:0]     CENTRE_LIMIT_RST   = 8'd115;

    // Register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAFE_RANGE     = 3'd0,
        CFG_CRITICAL_RANGE = 3'd1,
        CFG_FAST_SPEED     = 3'd2,
        CFG_SLOW_SPEED     = 3'd3,
        CFG_RIGHT_LIMIT    = 3'd4,
        CFG_CENTRE_LIMIT   = 3'd5
    } t_cfg_idx;

    // Register file contents
    typedef struct packed {
        logic [CFG_RANGE_W-1:0] clear_dist;
        logic [CFG_RANGE_W-1:0] spin_dist;
        logic [SPEED_W-1:0]     fast_speed;
        logic [SPEED_W-1:0]     slow_speed;
        logic [ANGLE_W-1:0]     right_limit;
        logic [ANGLE_W-1:0]     centre_limit;
    } t_cfg;

    // Classification of a finished sweep, made in the front
    typedef struct packed {
        logic clear_ahead;  // minimum at or above the safe range
        logic empty;        // some sector received no sample
        logic to_far;       // sweep ended at the low end, servo goes to 180
    } t_sweep_flags;

    // Magnitude and direction to a two's complement wheel command
    function automatic logic signed [WHEEL_W-1:0] to_speed(input logic [SPEED_W-1:0] mag,
                                                           input logic neg);
        logic signed [WHEEL_W-1:0] v;
        v = signed'({1'b0, mag});
        return neg ? WHEEL_W'(-v) : v;
    endfunction

endpackage

// ----- rtl/sts_if.sv -----
// Handshake interfaces of the sector scan obstacle steering block:
// sample input, steering command output and configuration write channel.
// Depends on sts_pkg.
interface sts_sample_if import sts_pkg::*; #(
    parameter int RANGE_BITS = RANGE_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [ANGLE_W-1:0]    servo_angle;
    logic [RANGE_BITS-1:0] range_reading;

    modport source (output valid, servo_angle, range_reading, input ready);
    modport sink   (input valid, servo_angle, range_reading, output ready);
endinterface

interface sts_cmd_if import sts_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [WHEEL_W-1:0] left_wheel_speed;
    logic signed [WHEEL_W-1:0] right_wheel_speed;
    logic [ANGLE_W-1:0]        servo_target;

    modport source (output valid, left_wheel_speed, right_wheel_speed, servo_target,
                    input ready);
    modport sink   (input valid, left_wheel_speed, right_wheel_speed, servo_target,
                    output ready);
endinterface

interface sts_cfg_if import sts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/sts_fifo.sv -----
// Small flop-based queue between the front and the back of the steering block.
// Depends on sts_pkg for the default depth.
module sts_fifo import sts_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic             o_full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    // Pointer advance with wrap at the depth
    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= bump(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= bump(r_rd_ptr);
            if (i_push && !i_pop)      r_count <= r_count + CNT_W'(1);
            else if (!i_push && i_pop) r_count <= r_count - CNT_W'(1);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
endmodule

// ----- rtl/sts_front.sv -----
// Front of the steering block: takes samples, keeps the sector totals and the
// running minimum, and queues a classified snapshot at each sweep end. Depends on sts_pkg and sts_if.
module sts_front import sts_pkg::*; #(
    parameter  int RANGE_BITS        = RANGE_BITS_DEF,
    parameter  int MAX_SWEEP_SAMPLES = MAX_SWEEP_SAMPLES_DEF,
    localparam int COUNT_W           = $clog2(MAX_SWEEP_SAMPLES + 1),
    localparam int SUM_W             = RANGE_BITS + COUNT_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sts_sample_if.sink         i_sample,
    input  t_cfg               i_cfg,
    input  logic               i_q_full,
    output logic               o_push,
    output t_sweep_flags       o_flags,
    output logic [SUM_W-1:0]   o_right_sum,
    output logic [SUM_W-1:0]   o_centre_sum,
    output logic [SUM_W-1:0]   o_left_sum,
    output logic [COUNT_W-1:0] o_right_count,
    output logic [COUNT_W-1:0] o_centre_count,
    output logic [COUNT_W-1:0] o_left_count
);
    localparam int MIN_CMP_W = (RANGE_BITS > CFG_RANGE_W) ? RANGE_BITS : CFG_RANGE_W;

    logic [SUM_W-1:0]      r_rs, r_cs, r_ls;
    logic [COUNT_W-1:0]    r_rc, r_cc, r_lc;
    logic [RANGE_BITS-1:0] r_min;

    logic [SUM_W-1:0]      b_rs, b_cs, b_ls, n_rs, n_cs, n_ls;
    logic [COUNT_W-1:0]    b_rc, b_cc, b_lc, n_rc, n_cc, n_lc;
    logic [RANGE_BITS-1:0] b_min, n_min;
    logic                  w_accept, w_end, w_right, w_centre;
    logic [RANGE_BITS-1:0] w_dist;
    logic [SUM_W-1:0]      w_dist_ext;

    assign i_sample.ready = !i_q_full;
    assign w_accept = i_sample.valid && i_sample.ready;
    assign w_dist   = i_sample.range_reading;
    assign w_dist_ext = SUM_W'(w_dist);
    assign w_end    = (i_sample.servo_angle < ANGLE_LOW) || (i_sample.servo_angle > ANGLE_HIGH);

    // Sector by angle
    assign w_right  = i_sample.servo_angle < i_cfg.right_limit;
    assign w_centre = !w_right && (i_sample.servo_angle < i_cfg.centre_limit);

    // A sweep end restarts the totals before the sample is added
    always_comb begin
        b_rs  = w_end ? '0 : r_rs;
        b_cs  = w_end ? '0 : r_cs;
        b_ls  = w_end ? '0 : r_ls;
        b_rc  = w_end ? '0 : r_rc;
        b_cc  = w_end ? '0 : r_cc;
        b_lc  = w_end ? '0 : r_lc;
        b_min = w_end ? RANGE_BITS'(MIN_RESET) : r_min;
    end

    // Accumulate into one sector, saturating its count
    always_comb begin
        n_rs = b_rs;
        n_cs = b_cs;
        n_ls = b_ls;
        n_rc = b_rc;
        n_cc = b_cc;
        n_lc = b_lc;
        if (w_right) begin
            if (b_rc < COUNT_W'(MAX_SWEEP_SAMPLES)) begin
                n_rc = b_rc + COUNT_W'(1);
                n_rs = b_rs + w_dist_ext;
            end
        end else if (w_centre) begin
            if (b_cc < COUNT_W'(MAX_SWEEP_SAMPLES)) begin
                n_cc = b_cc + COUNT_W'(1);
                n_cs = b_cs + w_dist_ext;
            end
        end else begin
            if (b_lc < COUNT_W'(MAX_SWEEP_SAMPLES)) begin
                n_lc = b_lc + COUNT_W'(1);
                n_ls = b_ls + w_dist_ext;
            end
        end
        n_min = (w_dist < b_min) ? w_dist : b_min;
    end

    // Totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs  <= '0;
            r_cs  <= '0;
            r_ls  <= '0;
            r_rc  <= '0;
            r_cc  <= '0;
            r_lc  <= '0;
            r_min <= RANGE_BITS'(MIN_RESET);
        end else if (w_accept) begin
            r_rs  <= n_rs;
            r_cs  <= n_cs;
            r_ls  <= n_ls;
            r_rc  <= n_rc;
            r_cc  <= n_cc;
            r_lc  <= n_lc;
            r_min <= n_min;
        end
    end

    // Snapshot of the finished sweep
    assign o_push              = w_accept && w_end;
    assign o_flags.clear_ahead = MIN_CMP_W'(r_min) >= MIN_CMP_W'(i_cfg.clear_dist);
    assign o_flags.empty       = (r_rc == '0) || (r_cc == '0) || (r_lc == '0);
    assign o_flags.to_far      = i_sample.servo_angle < ANGLE_LOW;
    assign o_right_sum    = r_rs;
    assign o_centre_sum   = r_cs;
    assign o_left_sum     = r_ls;
    assign o_right_count  = r_rc;
    assign o_centre_count = r_cc;
    assign o_left_count   = r_lc;
endmodule

// ----- rtl/sts_back.sv -----
// Back of the steering block: takes sweep snapshots from the queue, forms the
// cross products in one stage and decides the wheel command in the next. Depends on sts_pkg and sts_if.
module sts_back import sts_pkg::*; #(
    parameter  int RANGE_BITS        = RANGE_BITS_DEF,
    parameter  int MAX_SWEEP_SAMPLES = MAX_SWEEP_SAMPLES_DEF,
    localparam int COUNT_W           = $clog2(MAX_SWEEP_SAMPLES + 1),
    localparam int SUM_W             = RANGE_BITS + COUNT_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_pop,
    input  t_sweep_flags       i_flags,
    input  logic [SUM_W-1:0]   i_right_sum,
    input  logic [SUM_W-1:0]   i_centre_sum,
    input  logic [SUM_W-1:0]   i_left_sum,
    input  logic [COUNT_W-1:0] i_right_count,
    input  logic [COUNT_W-1:0] i_centre_count,
    input  logic [COUNT_W-1:0] i_left_count,
    input  t_cfg               i_cfg,
    sts_cmd_if.source          o_cmd
);
    localparam int PROD_W = SUM_W + COUNT_W;
    localparam int CRIT_W = CFG_RANGE_W + COUNT_W;
    localparam int CMP_W  = (SUM_W > CRIT_W) ? SUM_W : CRIT_W;

    // Product stage
    logic                      r_s1_valid;
    t_sweep_flags              r_s1_flags;
    logic [PROD_W-1:0]         r_lx, r_rx;
    logic [CRIT_W-1:0]         r_cx;
    logic [SUM_W-1:0]          r_cs;
    // Output stage
    logic                      r_o_valid;
    logic signed [WHEEL_W-1:0] r_o_left, r_o_right;
    logic [ANGLE_W-1:0]        r_o_target;

    logic                      w_out_free, w_s1_free, w_left_wider, w_spin;
    logic signed [WHEEL_W-1:0] n_left, n_right;
    logic signed [WHEEL_W-1:0] w_fast, w_slow;

    // Stall chain
    assign w_out_free = !r_o_valid || o_cmd.ready;
    assign w_s1_free  = !r_s1_valid || w_out_free;
    assign o_pop      = i_q_valid && w_s1_free;

    // Cross products of sums and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_flags <= i_flags;
            r_lx       <= PROD_W'(i_left_sum) * PROD_W'(i_right_count);
            r_rx       <= PROD_W'(i_right_sum) * PROD_W'(i_left_count);
            r_cx       <= CRIT_W'(i_cfg.spin_dist) * CRIT_W'(i_centre_count);
            r_cs       <= i_centre_sum;
        end
    end

    // Decision
    assign w_left_wider = r_lx > r_rx;
    assign w_spin       = CMP_W'(r_cs) < CMP_W'(r_cx);
    assign w_fast       = to_speed(i_cfg.fast_speed, 1'b0);
    assign w_slow       = to_speed(i_cfg.slow_speed, 1'b0);

    always_comb begin
        if (r_s1_flags.clear_ahead) begin
            n_left  = w_fast;
            n_right = w_fast;
        end else if (r_s1_flags.empty) begin
            n_left  = w_slow;
            n_right = w_fast;
        end else if (w_spin) begin
            n_left  = to_speed(i_cfg.slow_speed, w_left_wider);
            n_right = to_speed(i_cfg.slow_speed, !w_left_wider);
        end else if (w_left_wider) begin
            n_left  = w_slow;
            n_right = w_fast;
        end else begin
            n_left  = w_fast;
            n_right = w_slow;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_free) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_o_left   <= n_left;
            r_o_right  <= n_right;
            r_o_target <= r_s1_flags.to_far ? SERVO_FAR : SERVO_NEAR;
        end
    end

    assign o_cmd.valid             = r_o_valid;
    assign o_cmd.left_wheel_speed  = r_o_left;
    assign o_cmd.right_wheel_speed = r_o_right;
    assign o_cmd.servo_target      = r_o_target;
endmodule

// ----- rtl/sector_scan_obstacle_steering.sv -----
// Sector scan obstacle steering: top level.
// Holds the register file and joins front, queue and back. Depends on sts_pkg, sts_if,
// sts_front, sts_fifo and sts_back.
//
// Usage
//   i_sample carries one scanner sample per transaction: servo angle and range reading.
//   A sample at an angle below 1 or above 179 closes the sweep; one steering command
//   (left and right wheel speed, new servo end target) then leaves on o_cmd, decided
//   from the totals of the sweep before it. Every sample, the closing one included,
//   then counts towards the next sweep.
//   i_cfg writes the six registers (index, data); it is always ready and should be
//   used only while no command is pending.
// Timing
//   One sample per cycle is taken while i_sample.ready is high. After the closing
//   sample's transaction its snapshot passes the queue and the product stage, after
//   which the decision fills the output register.
//   A two-entry queue between front and back absorbs stalls; i_sample.ready falls only
//   when that queue is full, i.e. when o_cmd is stalled and further sweeps close.
// Reset
//   i_rst_n (synchronous, active low) loads the register defaults, clears all totals,
//   sets the running minimum to 255 and empties the pipeline.
module sector_scan_obstacle_steering import sts_pkg::*; #(
    parameter int RANGE_BITS        = RANGE_BITS_DEF,
    parameter int MAX_SWEEP_SAMPLES = MAX_SWEEP_SAMPLES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sts_sample_if.sink i_sample,
    sts_cmd_if.source  o_cmd,
    sts_cfg_if.sink    i_cfg
);
    localparam int COUNT_W = $clog2(MAX_SWEEP_SAMPLES + 1);
    localparam int SUM_W   = RANGE_BITS + COUNT_W;
    localparam int FLAG_W  = $bits(t_sweep_flags);
    localparam int Q_W     = FLAG_W + 3 * SUM_W + 3 * COUNT_W;

    t_cfg                r_cfg;

    logic                w_push, w_q_full, w_q_valid, w_pop;
    t_sweep_flags        w_f_flags, w_b_flags;
    logic [SUM_W-1:0]    w_f_rs, w_f_cs, w_f_ls, w_b_rs, w_b_cs, w_b_ls;
    logic [COUNT_W-1:0]  w_f_rc, w_f_cc, w_f_lc, w_b_rc, w_b_cc, w_b_lc;
    logic [Q_W-1:0]      w_q_in, w_q_out;

    // Register file
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clear_dist     <= SAFE_RANGE_RST;
            r_cfg.spin_dist      <= CRITICAL_RANGE_RST;
            r_cfg.fast_speed     <= FAST_SPEED_RST;
            r_cfg.slow_speed     <= SLOW_SPEED_RST;
            r_cfg.right_limit    <= RIGHT_LIMIT_RST;
            r_cfg.centre_limit   <= CENTRE_LIMIT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_SAFE_RANGE:     r_cfg.clear_dist     <= i_cfg.data[CFG_RANGE_W-1:0];
                CFG_CRITICAL_RANGE: r_cfg.spin_dist      <= i_cfg.data[CFG_RANGE_W-1:0];
                CFG_FAST_SPEED:     r_cfg.fast_speed     <= i_cfg.data[SPEED_W-1:0];
                CFG_SLOW_SPEED:     r_cfg.slow_speed     <= i_cfg.data[SPEED_W-1:0];
                CFG_RIGHT_LIMIT:    r_cfg.right_limit    <= i_cfg.data[ANGLE_W-1:0];
                CFG_CENTRE_LIMIT:   r_cfg.centre_limit   <= i_cfg.data[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: sample intake and sector totals
    sts_front #(
        .RANGE_BITS        (RANGE_BITS),
        .MAX_SWEEP_SAMPLES (MAX_SWEEP_SAMPLES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample       (i_sample),
        .i_cfg          (r_cfg),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_flags        (w_f_flags),
        .o_right_sum    (w_f_rs),
        .o_centre_sum   (w_f_cs),
        .o_left_sum     (w_f_ls),
        .o_right_count  (w_f_rc),
        .o_centre_count (w_f_cc),
        .o_left_count   (w_f_lc)
    );

    // Snapshot queue
    assign w_q_in = {w_f_flags, w_f_rs, w_f_cs, w_f_ls, w_f_rc, w_f_cc, w_f_lc};
    assign {w_b_flags, w_b_rs, w_b_cs, w_b_ls, w_b_rc, w_b_cc, w_b_lc} = w_q_out;

    sts_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_valid (w_q_valid),
        .o_full  (w_q_full)
    );

    // Back: decision and command output
    sts_back #(
        .RANGE_BITS        (RANGE_BITS),
        .MAX_SWEEP_SAMPLES (MAX_SWEEP_SAMPLES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .o_pop          (w_pop),
        .i_flags        (w_b_flags),
        .i_right_sum    (w_b_rs),
        .i_centre_sum   (w_b_cs),
        .i_left_sum     (w_b_ls),
        .i_right_count  (w_b_rc),
        .i_centre_count (w_b_cc),
        .i_left_count   (w_b_lc),
        .i_cfg          (r_cfg),
        .o_cmd          (o_cmd)
    );

    // Checks
    a_end_queues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready && i_sample.servo_angle == SERVO_NEAR) |-> w_push)
        else $error("sweep end at angle zero did not queue a command");

    a_queue_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> w_q_valid)
        else $error("queue empty right after a snapshot transaction");

    a_no_reverse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.valid |-> !(o_cmd.left_wheel_speed < 0 && o_cmd.right_wheel_speed < 0))
        else $error("both wheels commanded backwards");

    a_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.valid |-> (o_cmd.servo_target == SERVO_NEAR || o_cmd.servo_target == SERVO_FAR))
        else $error("servo target is neither end of the sweep");
endmodule

// ----- test/sts_checker.sv -----
`timescale 1ns / 100ps
// Checker for the sector scan obstacle steering block: watches the sample, command and
// register write channels, predicts every steering command and compares it field by field.
// Depends on sts_pkg and sts_if.
module sts_checker import sts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sts_sample_if i_sample,
    sts_cmd_if    i_cmd,
    sts_cfg_if    i_cfg,
    output int    o_mismatches,
    output int    o_steering_due
);

    localparam int RANGE_W      = RANGE_BITS_DEF;
    localparam int COUNT_W      = $clog2(MAX_SWEEP_SAMPLES_DEF) + 1;
    localparam int SUM_W        = RANGE_W + COUNT_W;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic signed [WHEEL_W-1:0] left_speed;
        logic signed [WHEEL_W-1:0] right_speed;
        logic [ANGLE_W-1:0]        target;
    } t_steering;

    // Own copy of the registers and of the sweep totals
    t_cfg               regs;
    logic [SUM_W-1:0]   right_sum, centre_sum, left_sum;
    logic [COUNT_W-1:0] right_cnt, centre_cnt, left_cnt;
    logic [RANGE_W-1:0] nearest;

    t_steering steering_due[$];
    int        mismatch_count = 0;
    int        due_count      = 0;

    assign o_mismatches   = mismatch_count;
    assign o_steering_due = due_count;

    // Magnitude plus direction as an 8-bit two's complement speed
    function automatic logic [WHEEL_W-1:0] wheel(input logic [SPEED_W-1:0] mag,
                                                 input logic reverse);
        logic [WHEEL_W-1:0] fwd;
        fwd = {1'b0, mag};
        return reverse ? ~fwd + 1'b1 : fwd;
    endfunction

    // Steering decision from the totals of the sweep that is closing
    function automatic t_steering steer_for_sweep(input logic [ANGLE_W-1:0] angle);
        t_steering   cmd;
        logic        left_wider;
        logic [63:0] left_side;
        logic [63:0] right_side;
        cmd.target = (angle < ANGLE_LOW) ? SERVO_FAR : SERVO_NEAR;
        // averages compared by cross-multiplying sums and counts
        left_side  = 64'(left_sum) * 64'(right_cnt);
        right_side = 64'(right_sum) * 64'(left_cnt);
        left_wider = left_side > right_side;
        if (nearest >= regs.clear_dist) begin
            cmd.left_speed  = wheel(regs.fast_speed, 1'b0);
            cmd.right_speed = wheel(regs.fast_speed, 1'b0);
        end else if (left_cnt == 0 || right_cnt == 0 || centre_cnt == 0) begin
            cmd.left_speed  = wheel(regs.slow_speed, 1'b0);
            cmd.right_speed = wheel(regs.fast_speed, 1'b0);
        end else if (64'(centre_sum) < 64'(regs.spin_dist) * 64'(centre_cnt)) begin
            // spin on the spot towards the side with more room
            cmd.left_speed  = wheel(regs.slow_speed, left_wider);
            cmd.right_speed = wheel(regs.slow_speed, !left_wider);
        end else if (left_wider) begin
            cmd.left_speed  = wheel(regs.slow_speed, 1'b0);
            cmd.right_speed = wheel(regs.fast_speed, 1'b0);
        end else begin
            cmd.left_speed  = wheel(regs.fast_speed, 1'b0);
            cmd.right_speed = wheel(regs.slow_speed, 1'b0);
        end
        return cmd;
    endfunction

    task automatic clear_sweep();
        right_sum  = '0;
        centre_sum = '0;
        left_sum   = '0;
        right_cnt  = '0;
        centre_cnt = '0;
        left_cnt   = '0;
        nearest    = RANGE_W'(MIN_RESET);
    endtask

    task automatic restore_regs();
        regs.clear_dist     = SAFE_RANGE_RST;
        regs.spin_dist      = CRITICAL_RANGE_RST;
        regs.fast_speed     = FAST_SPEED_RST;
        regs.slow_speed     = SLOW_SPEED_RST;
        regs.right_limit    = RIGHT_LIMIT_RST;
        regs.centre_limit   = CENTRE_LIMIT_RST;
    endtask

    // A full sector ignores further samples
    task automatic add_to_sector(inout logic [SUM_W-1:0] sum, inout logic [COUNT_W-1:0] cnt,
                                 input logic [RANGE_W-1:0] reading);
        if (cnt < COUNT_W'(MAX_SWEEP_SAMPLES_DEF)) begin
            cnt = cnt + 1'b1;
            sum = sum + SUM_W'(reading);
        end
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SAFE_RANGE:     regs.clear_dist     = data[CFG_RANGE_W-1:0];
            CFG_CRITICAL_RANGE: regs.spin_dist      = data[CFG_RANGE_W-1:0];
            CFG_FAST_SPEED:     regs.fast_speed     = data[SPEED_W-1:0];
            CFG_SLOW_SPEED:     regs.slow_speed     = data[SPEED_W-1:0];
            CFG_RIGHT_LIMIT:    regs.right_limit    = data[ANGLE_W-1:0];
            CFG_CENTRE_LIMIT:   regs.centre_limit   = data[ANGLE_W-1:0];
            default: ;  // spare indices change nothing
        endcase
    endtask

    // Closing sample first decides and clears, then every sample is binned
    task automatic take_sample(input logic [ANGLE_W-1:0] angle,
                               input logic [RANGE_W-1:0] reading);
        if (angle < ANGLE_LOW || angle > ANGLE_HIGH) begin
            steering_due.push_back(steer_for_sweep(angle));
            clear_sweep();
        end
        if (angle < regs.right_limit) begin
            add_to_sector(right_sum, right_cnt, reading);
        end else if (angle < regs.centre_limit) begin
            add_to_sector(centre_sum, centre_cnt, reading);
        end else begin
            add_to_sector(left_sum, left_cnt, reading);
        end
        if (reading < nearest) begin
            nearest = reading;
        end
    endtask

    // Monitor: register writes, then commands, then samples of the same edge
    always @(posedge i_clk) begin
        t_steering got;
        t_steering want;
        if (!i_rst_n) begin
            restore_regs();
            clear_sweep();
            steering_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                apply_write(i_cfg.index, i_cfg.data);
            end
            if (i_cmd.valid && i_cmd.ready) begin
                got.left_speed  = i_cmd.left_wheel_speed;
                got.right_speed = i_cmd.right_wheel_speed;
                got.target      = i_cmd.servo_target;
                if (steering_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: expected no command, got L=%0d R=%0d T=%0d",
                                 $realtime, got.left_speed, got.right_speed, got.target);
                    end
                end else begin
                    want = steering_due.pop_front();
                    if (got.left_speed != want.left_speed ||
                        got.right_speed != want.right_speed ||
                        got.target != want.target) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display({"%0t: command mismatch, expected L=%0d R=%0d T=%0d,",
                                      " got L=%0d R=%0d T=%0d"},
                                     $realtime, want.left_speed, want.right_speed,
                                     want.target, got.left_speed, got.right_speed,
                                     got.target);
                        end
                    end
                end
            end
            if (i_sample.valid && i_sample.ready) begin
                take_sample(i_sample.servo_angle, i_sample.range_reading);
            end
        end
        due_count = steering_due.size();
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the sector scan obstacle steering block: drives sweeps of samples and
// register writes, stalls the command channel and gives the verdict.
// Depends on sts_pkg, sts_if, sector_scan_obstacle_steering and sts_checker.
module tb;
    import sts_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANGE_W        = RANGE_BITS_DEF;
    localparam int RANGE_MAX      = (1 << RANGE_W) - 1;
    localparam int ANGLE_MAX      = (1 << ANGLE_W) - 1;

    // Indices past the register list, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    // How the readings of one sweep are spread
    typedef enum int {SPREAD_ANY, SPREAD_NEAR, SPREAD_FAR, SPREAD_TIGHT} t_spread;

    // Directed sweeps at reset settings: clear ahead, spins both ways, curves both ways,
    // equal averages, empty sector, all closing angles, extreme readings
    localparam logic [ANGLE_W-1:0] DIR_ANGLE [0:19] = '{
        8'd0, 8'd90, 8'd150, 8'd180, 8'd10, 8'd100, 8'd255, 8'd20, 8'd100, 8'd0,
        8'd140, 8'd100, 8'd1, 8'd179, 8'd180, 8'd10, 8'd90, 8'd0, 8'd100, 8'd200};
    localparam logic [RANGE_W-1:0] DIR_RANGE [0:19] = '{
        10'd1023, 10'd20, 10'd40, 10'd900, 10'd100, 10'd10, 10'd5, 10'd200, 10'd300, 10'd0,
        10'd500, 10'd40, 10'd7, 10'd60, 10'd40, 10'd40, 10'd40, 10'd1023, 10'd10, 10'd10};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   calm     = 1'b0;
    bit   hold_off = 1'b0;
    int   quiet_cycles = 0;
    int   mismatches;
    int   steering_due;

    sts_sample_if smp_if ();
    sts_cmd_if    cmd_if ();
    sts_cfg_if    cfg_if ();

    sector_scan_obstacle_steering DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_cmd    (cmd_if),
        .i_cfg    (cfg_if)
    );

    sts_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample       (smp_if),
        .i_cmd          (cmd_if),
        .i_cfg          (cfg_if),
        .o_mismatches   (mismatches),
        .o_steering_due (steering_due)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog: ends the run after too long without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((smp_if.valid && smp_if.ready) || (cmd_if.valid && cmd_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Command receiver: short random stalls, or one long hold when asked
    initial begin
        cmd_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                cmd_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                cmd_if.ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge i_clk);
            end else begin
                cmd_if.ready <= 1'b1;
            end
        end
    end

    function automatic logic [RANGE_W-1:0] pick_range(input t_spread spread);
        case (spread)
            SPREAD_NEAR:  return RANGE_W'($urandom_range(0, 120));
            SPREAD_FAR:   return RANGE_W'($urandom_range(MIN_RESET, RANGE_MAX));
            SPREAD_TIGHT: return RANGE_W'($urandom_range(0, 60));
            default:      return RANGE_W'($urandom_range(0, RANGE_MAX));
        endcase
    endfunction

    // One sample transaction, sometimes after a short gap
    task automatic send_sample(input logic [ANGLE_W-1:0] angle,
                               input logic [RANGE_W-1:0] reading);
        if (!calm && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge i_clk);
        end
        @(negedge i_clk);
        smp_if.valid         <= 1'b1;
        smp_if.servo_angle   <= angle;
        smp_if.range_reading <= reading;
        do @(posedge i_clk); while (!smp_if.ready);
    endtask

    // Stop offering samples and wait until every command has left the block
    task automatic finish_phase();
        @(negedge i_clk);
        smp_if.valid <= 1'b0;
        while (steering_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic write_setting(input logic [CFG_DATA_W-1:0] safe,
                                 input logic [CFG_DATA_W-1:0] critical,
                                 input logic [CFG_DATA_W-1:0] fast,
                                 input logic [CFG_DATA_W-1:0] slow,
                                 input logic [CFG_DATA_W-1:0] right_lim,
                                 input logic [CFG_DATA_W-1:0] centre_lim);
        write_reg(CFG_SAFE_RANGE, safe);
        write_reg(CFG_CRITICAL_RANGE, critical);
        write_reg(CFG_FAST_SPEED, fast);
        write_reg(CFG_SLOW_SPEED, slow);
        write_reg(CFG_RIGHT_LIMIT, right_lim);
        write_reg(CFG_CENTRE_LIMIT, centre_lim);
    endtask

    task automatic random_setting();
        int right_lim;
        right_lim = $urandom_range(1, 120);
        write_setting(CFG_DATA_W'($urandom_range(0, 300)), CFG_DATA_W'($urandom_range(0, 700)),
                      CFG_DATA_W'($urandom_range(0, 127)), CFG_DATA_W'($urandom_range(0, 127)),
                      CFG_DATA_W'(right_lim), CFG_DATA_W'(right_lim + $urandom_range(1, 60)));
    endtask

    // Mostly whole sweeps with random content, some stray transactions
    task automatic run_sweeps(input int n_items);
        int                 sent;
        int                 len;
        t_spread            spread;
        logic [ANGLE_W-1:0] close_angle;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 6) == 0) begin
                send_sample(ANGLE_W'($urandom_range(0, ANGLE_MAX)),
                            RANGE_W'($urandom_range(0, RANGE_MAX)));
                sent++;
            end else begin
                len    = $urandom_range(0, 14);
                spread = t_spread'($urandom_range(0, 3));
                repeat (len) send_sample(ANGLE_W'($urandom_range(1, 179)), pick_range(spread));
                close_angle = ($urandom_range(0, 1) != 0) ? SERVO_FAR : SERVO_NEAR;
                if ($urandom_range(0, 3) == 0) begin
                    close_angle = ANGLE_W'($urandom_range(181, ANGLE_MAX));
                end
                send_sample(close_angle, pick_range(spread));
                sent += len + 1;
            end
        end
    endtask

    // Main sequence
    initial begin
        smp_if.valid         = 1'b0;
        smp_if.servo_angle   = '0;
        smp_if.range_reading = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed sweeps at reset settings
        foreach (DIR_ANGLE[k]) send_sample(DIR_ANGLE[k], DIR_RANGE[k]);
        finish_phase();

        // extremes: always clear ahead, no right sector
        write_setting(10'd0, 10'd1023, 10'd127, 10'd0, 10'd0, 10'd180);
        write_reg(CFG_SPARE_6, CFG_DATA_W'($urandom_range(0, RANGE_MAX)));
        run_sweeps(60);
        finish_phase();

        // all ones on every register, upper data bits must be dropped
        write_setting('1, '1, '1, '1, '1, '1);
        write_reg(CFG_SPARE_7, CFG_DATA_W'($urandom_range(0, RANGE_MAX)));
        run_sweeps(60);
        finish_phase();

        // crossed limits: the centre sector never fills
        write_setting(10'd1023, 10'd0, 10'd0, 10'd127, 10'd180, 10'd0);
        run_sweeps(60);
        finish_phase();

        for (int p = 0; p < 8; p++) begin
            random_setting();
            run_sweeps(75);
            finish_phase();
        end

        // back-pressure: long receiver hold while short sweeps keep closing
        random_setting();
        hold_off = 1'b1;
        repeat (20) begin
            send_sample(ANGLE_W'($urandom_range(1, 179)), pick_range(SPREAD_ANY));
            send_sample(SERVO_FAR, pick_range(SPREAD_ANY));
        end
        finish_phase();

        // last stretch at reset settings, no stalls on either side
        write_setting(CFG_DATA_W'(SAFE_RANGE_RST), CFG_DATA_W'(CRITICAL_RANGE_RST),
                      CFG_DATA_W'(FAST_SPEED_RST), CFG_DATA_W'(SLOW_SPEED_RST),
                      CFG_DATA_W'(RIGHT_LIMIT_RST), CFG_DATA_W'(CENTRE_LIMIT_RST));
        calm = 1'b1;
        run_sweeps(80);
        finish_phase();

        if (mismatches == 0 && steering_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sts_pkg.sv
rtl/sts_if.sv
rtl/sts_fifo.sv
rtl/sts_front.sv
rtl/sts_back.sv
rtl/sector_scan_obstacle_steering.sv
test/sts_checker.sv
test/tb.sv
